// ===== hw/rtl/mpmc_pkg.sv =====
// Shared types, command codes and micro-operation codes of the pattern match counter.
package mpmc_pkg;

  // Item commands
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PAT   = 3'd1;
  localparam logic [2:0] CMD_BUILD = 3'd2;
  localparam logic [2:0] CMD_TEXT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NODEFULL = 2'd1;
  localparam logic [1:0] ST_PATFULL  = 2'd2;
  localparam logic [1:0] ST_BADIDX   = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] letter;
    logic       last;
    logic [7:0] pattern_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] count;
    logic [23:0] max_count;
    logic        is_max;
  } result_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CLR, OP_ZROW, OP_MULC, OP_MULM, OP_RDL, OP_PINS,
    OP_DEAD, OP_PLAST, OP_BINIT, OP_RDC, OP_B1, OP_RDQ, OP_RDF, OP_MULF,
    OP_RDV, OP_RDVIA, OP_B2, OP_TS, OP_RDW, OP_HIT, OP_RDP, OP_BAD,
    OP_RDH, OP_RES
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic built;
    logic letter_ok;
    logic last;
    logic pidx_ok;
    logic dead;
    logic child_zero;
    logic room;
    logic c_last;
    logic q_more;
    logic f_nz;
  } stat_t;

endpackage

// ===== hw/rtl/mpmc_dpath.sv =====
// Datapath of the pattern match counter: trie memories, BFS queue, counters.
module mpmc_dpath #(
  parameter int MAX_NODES    = 4096,
  parameter int MAX_PATTERNS = 256,
  parameter int ALPHABET     = 26,
  parameter int COUNT_BITS   = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpmc_pkg::item_t  item_i,
  input  mpmc_pkg::ctrl_t  ctrl_i,
  output mpmc_pkg::stat_t  stat_o,
  output mpmc_pkg::result_t result_o
);
  import mpmc_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int GB = $clog2(MAX_NODES * ALPHABET);
  localparam int CB = $clog2(ALPHABET);
  localparam int TB = $clog2(MAX_NODES + 1);
  localparam int PB = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int UB = $clog2(MAX_PATTERNS + 1);

  // Memories
  logic [NB-1:0]         goto_mem [MAX_NODES*ALPHABET];
  logic [NB-1:0]         fail_mem [MAX_NODES];
  logic                  term_mem [MAX_NODES];
  logic [COUNT_BITS-1:0] hits_mem [MAX_NODES];
  logic [NB-1:0]         pend_mem [MAX_PATTERNS];
  logic [NB-1:0]         queue_mem[MAX_NODES];

  // Registers
  item_t                 item_q, item_d;
  logic [NB-1:0]         nodes_q, nodes_d, cursor_q, cursor_d, match_q, match_d;
  logic [UB-1:0]         pu_q, pu_d;
  logic [COUNT_BITS-1:0] max_q, max_d, count_q, count_d;
  logic                  built_q, built_d, dead_q, dead_d, is_max_q, is_max_d;
  logic [TB-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CB-1:0]         c_q, c_d;
  logic [GB-1:0]         prod_q, prod_d, slot_q, slot_d, base_u_q, base_u_d;
  logic [GB-1:0]         base_f_q, base_f_d;
  logic [NB-1:0]         v_q, v_d, f_q, f_d, node_q, node_d;
  logic [1:0]            status_q, status_d;

  // Registered read data
  logic [NB-1:0]         gt_rd_q, fl_rd_q, q_rd_q, pe_rd_q;
  logic                  tf_rd_q;
  logic [COUNT_BITS-1:0] hit_rd_q;

  // Memory port controls
  logic                  gt_re, gt_we, fl_re, fl_we, q_re, q_we;
  logic                  tf_we, hit_re, hit_we, pe_re, pe_we, rdw;
  logic [GB-1:0]         gt_ra, gt_wa;
  logic [NB-1:0]         gt_wd, fl_ra, fl_wa, fl_wd, tf_wa, hit_ra, hit_wa, pe_wd;
  logic                  tf_wd;
  logic [COUNT_BITS-1:0] hit_wd, hit_inc;
  logic [NB-1:0]         mul_x, alloc_node, s_node, end_node;
  logic [GB-1:0]         mul_p;
  logic                  tail_room, pat_full;

  assign mul_p      = GB'(mul_x) * GB'(ALPHABET);
  assign alloc_node = NB'(nodes_q + 1'b1);
  assign tail_room  = 32'(tail_q) < MAX_NODES;
  assign pat_full   = 32'(pu_q) >= MAX_PATTERNS;
  assign end_node   = dead_q ? '0 : cursor_q;
  assign s_node     = stat_o.letter_ok ? gt_rd_q : '0;
  assign hit_inc    = (&hit_rd_q) ? hit_rd_q : COUNT_BITS'(hit_rd_q + 1'b1);

  // Status toward the controller
  always_comb begin
    stat_o.built      = built_q;
    stat_o.letter_ok  = 32'(item_q.letter) < ALPHABET;
    stat_o.last       = item_q.last;
    stat_o.pidx_ok    = 32'(item_q.pattern_index) < 32'(pu_q);
    stat_o.dead       = dead_q;
    stat_o.child_zero = (gt_rd_q == '0);
    stat_o.room       = (32'(nodes_q) + 1) < MAX_NODES;
    stat_o.c_last     = (c_q == CB'(ALPHABET - 1));
    stat_o.q_more     = (head_q != tail_q);
    stat_o.f_nz       = (f_q != '0);
  end

  // Next-state and memory control per micro-operation
  always_comb begin
    item_d = item_q;   nodes_d = nodes_q;   cursor_d = cursor_q; match_d = match_q;
    pu_d = pu_q;       max_d = max_q;       count_d = count_q;   built_d = built_q;
    dead_d = dead_q;   is_max_d = is_max_q; head_d = head_q;     tail_d = tail_q;
    c_d = c_q;         prod_d = prod_q;     slot_d = slot_q;     base_u_d = base_u_q;
    base_f_d = base_f_q; v_d = v_q;         f_d = f_q;           node_d = node_q;
    status_d = status_q;
    mul_x = cursor_q;
    gt_re = 1'b0; gt_we = 1'b0; fl_re = 1'b0; fl_we = 1'b0; q_re = 1'b0; q_we = 1'b0;
    tf_we = 1'b0; hit_re = 1'b0; hit_we = 1'b0; pe_re = 1'b0; pe_we = 1'b0; rdw = 1'b0;
    gt_ra = prod_q + GB'(c_q); gt_wa = prod_q + GB'(c_q); gt_wd = '0;
    fl_ra = f_q; fl_wa = alloc_node; fl_wd = '0;
    tf_wa = alloc_node; tf_wd = 1'b0;
    hit_ra = f_q; hit_wa = alloc_node; hit_wd = '0;
    pe_wd = end_node;
    case (ctrl_i.op)
      OP_LOAD: begin
        item_d = item_i; status_d = ST_OK; count_d = '0; is_max_d = 1'b0;
      end
      OP_CLR: begin
        nodes_d = '0; pu_d = '0; cursor_d = '0; match_d = '0; max_d = '0;
        built_d = 1'b0; dead_d = 1'b0; head_d = '0; tail_d = '0; c_d = '0; prod_d = '0;
      end
      OP_ZROW: begin
        gt_we = 1'b1; c_d = CB'(c_q + 1'b1);
      end
      OP_MULC: begin
        mul_x = cursor_q; prod_d = mul_p;
      end
      OP_MULM: begin
        mul_x = match_q; prod_d = mul_p;
      end
      OP_RDL: begin
        gt_re = 1'b1; gt_ra = prod_q + GB'(item_q.letter);
        slot_d = prod_q + GB'(item_q.letter);
      end
      OP_PINS: begin
        if (gt_rd_q != '0) begin
          cursor_d = gt_rd_q;
        end else if (stat_o.room) begin
          nodes_d = alloc_node; cursor_d = alloc_node; c_d = '0;
          gt_we = 1'b1; gt_wa = slot_q; gt_wd = alloc_node;
          fl_we = 1'b1; tf_we = 1'b1; hit_we = 1'b1;
        end else begin
          status_d = ST_NODEFULL; dead_d = 1'b1;
        end
      end
      OP_DEAD: begin
        if (!stat_o.letter_ok) dead_d = 1'b1;
      end
      OP_PLAST: begin
        if (pat_full) begin
          if (status_q == ST_OK) status_d = ST_PATFULL;
        end else begin
          pe_we = 1'b1;
          if (end_node != '0) begin
            tf_we = 1'b1; tf_wa = end_node; tf_wd = 1'b1;
          end
          pu_d = UB'(pu_q + 1'b1);
        end
        cursor_d = '0; dead_d = 1'b0;
      end
      OP_BINIT: begin
        cursor_d = '0; dead_d = 1'b0;
        if (!built_q) begin
          built_d = 1'b1; head_d = '0; tail_d = '0; c_d = '0; prod_d = '0;
        end
      end
      OP_RDC: begin
        gt_re = 1'b1;
      end
      OP_B1: begin
        if (gt_rd_q != '0 && tail_room) begin
          fl_we = 1'b1; fl_wa = gt_rd_q; fl_wd = '0;
          q_we = 1'b1; tail_d = TB'(tail_q + 1'b1);
        end
        c_d = CB'(c_q + 1'b1);
      end
      OP_RDQ: begin
        q_re = 1'b1; head_d = TB'(head_q + 1'b1);
      end
      OP_RDF: begin
        fl_re = 1'b1; fl_ra = q_rd_q; mul_x = q_rd_q; base_u_d = mul_p;
      end
      OP_MULF: begin
        mul_x = fl_rd_q; base_f_d = mul_p; c_d = '0;
      end
      OP_RDV: begin
        gt_re = 1'b1; gt_ra = base_u_q + GB'(c_q);
      end
      OP_RDVIA: begin
        v_d = gt_rd_q; gt_re = 1'b1; gt_ra = base_f_q + GB'(c_q);
      end
      OP_B2: begin
        if (v_q != '0) begin
          fl_we = 1'b1; fl_wa = v_q; fl_wd = gt_rd_q;
          if (tail_room) begin
            q_we = 1'b1; tail_d = TB'(tail_q + 1'b1);
          end
        end else begin
          gt_we = 1'b1; gt_wa = base_u_q + GB'(c_q); gt_wd = gt_rd_q;
        end
        c_d = CB'(c_q + 1'b1);
      end
      OP_TS: begin
        f_d = s_node; match_d = item_q.last ? '0 : s_node;
      end
      OP_RDW: begin
        rdw = 1'b1; fl_re = 1'b1; hit_re = 1'b1;
      end
      OP_HIT: begin
        if (tf_rd_q) begin
          hit_we = 1'b1; hit_wa = f_q; hit_wd = hit_inc;
          if (hit_inc > max_q) max_d = hit_inc;
        end
        f_d = fl_rd_q;
      end
      OP_RDP: begin
        pe_re = 1'b1;
      end
      OP_BAD: begin
        status_d = ST_BADIDX;
      end
      OP_RDH: begin
        hit_re = 1'b1; hit_ra = pe_rd_q; node_d = pe_rd_q;
      end
      OP_RES: begin
        count_d  = (node_q == '0) ? '0 : hit_rd_q;
        is_max_d = (((node_q == '0) ? '0 : hit_rd_q) == max_q);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= '0; pu_q <= '0; cursor_q <= '0; match_q <= '0; max_q <= '0;
      built_q <= 1'b0; dead_q <= 1'b0; head_q <= '0; tail_q <= '0; c_q <= '0;
    end else begin
      nodes_q <= nodes_d; pu_q <= pu_d; cursor_q <= cursor_d; match_q <= match_d;
      max_q <= max_d; built_q <= built_d; dead_q <= dead_d; head_q <= head_d;
      tail_q <= tail_d; c_q <= c_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d; count_q <= count_d; is_max_q <= is_max_d; status_q <= status_d;
    prod_q <= prod_d; slot_q <= slot_d; base_u_q <= base_u_d; base_f_q <= base_f_d;
    v_q <= v_d; f_q <= f_d; node_q <= node_d;
  end

  // Goto table
  always_ff @(posedge clk_i) begin
    if (gt_we) goto_mem[gt_wa] <= gt_wd;
    if (gt_re) gt_rd_q <= goto_mem[gt_ra];
  end

  // Fail links
  always_ff @(posedge clk_i) begin
    if (fl_we) fail_mem[fl_wa] <= fl_wd;
    if (fl_re) fl_rd_q <= fail_mem[fl_ra];
  end

  // Terminal flags
  always_ff @(posedge clk_i) begin
    if (tf_we) term_mem[tf_wa] <= tf_wd;
    if (rdw) tf_rd_q <= term_mem[f_q];
  end

  // Node hit counts
  always_ff @(posedge clk_i) begin
    if (hit_we) hits_mem[hit_wa] <= hit_wd;
    if (hit_re) hit_rd_q <= hits_mem[hit_ra];
  end

  // Pattern end nodes
  always_ff @(posedge clk_i) begin
    if (pe_we) pend_mem[pu_q[PB-1:0]] <= pe_wd;
    if (pe_re) pe_rd_q <= pend_mem[PB'(item_q.pattern_index)];
  end

  // BFS queue
  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[tail_q[NB-1:0]] <= (ctrl_i.op == OP_B1) ? gt_rd_q : v_q;
    if (q_re) q_rd_q <= queue_mem[head_q[NB-1:0]];
  end

  // Result fields
  assign result_o.status    = status_q;
  assign result_o.count     = 24'(count_q);
  assign result_o.max_count = 24'(max_q);
  assign result_o.is_max    = is_max_q;

  // Running maximum only moves up between clears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op != OP_CLR) |=> (max_q >= $past(max_q)))
    else $error("running maximum decreased");

  // Queue read side never passes the write side
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("BFS queue head beyond tail");

endmodule

// ===== hw/rtl/mpmc_ctrl.sv =====
// Controller state machine of the pattern match counter.
module mpmc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [2:0]      command_i,
  input  mpmc_pkg::stat_t stat_i,
  output mpmc_pkg::ctrl_t ctrl_o,
  output logic            busy,
  output logic            done_o
);
  import mpmc_pkg::*;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IZERO  = 5'd1;
  localparam logic [4:0] S_IDLE   = 5'd2;
  localparam logic [4:0] S_DONE   = 5'd3;
  localparam logic [4:0] S_CLR    = 5'd4;
  localparam logic [4:0] S_ZERO   = 5'd5;
  localparam logic [4:0] S_P_CHK  = 5'd6;
  localparam logic [4:0] S_P_RD   = 5'd7;
  localparam logic [4:0] S_P_INS  = 5'd8;
  localparam logic [4:0] S_P_MULN = 5'd9;
  localparam logic [4:0] S_P_ZROW = 5'd10;
  localparam logic [4:0] S_P_LAST = 5'd11;
  localparam logic [4:0] S_B_CHK  = 5'd12;
  localparam logic [4:0] S_B_RDC  = 5'd13;
  localparam logic [4:0] S_B_1    = 5'd14;
  localparam logic [4:0] S_B_Q    = 5'd15;
  localparam logic [4:0] S_B_RDF  = 5'd16;
  localparam logic [4:0] S_B_MULF = 5'd17;
  localparam logic [4:0] S_B_RDV  = 5'd18;
  localparam logic [4:0] S_B_VIA  = 5'd19;
  localparam logic [4:0] S_B_2    = 5'd20;
  localparam logic [4:0] S_T_CHK  = 5'd21;
  localparam logic [4:0] S_T_RD   = 5'd22;
  localparam logic [4:0] S_T_S    = 5'd23;
  localparam logic [4:0] S_T_W    = 5'd24;
  localparam logic [4:0] S_T_HIT  = 5'd25;
  localparam logic [4:0] S_R_CHK  = 5'd26;
  localparam logic [4:0] S_R_RDH  = 5'd27;
  localparam logic [4:0] S_R_RES  = 5'd28;

  logic [4:0] state_q, state_d;
  logic       accept;

  assign busy   = !(state_q == S_IDLE || state_q == S_DONE);
  assign done_o = (state_q == S_DONE);
  assign accept = start && !busy;

  // Sequencing
  always_comb begin
    state_d   = state_q;
    ctrl_o.op = OP_NOP;
    case (state_q)
      S_INIT: begin
        ctrl_o.op = OP_CLR; state_d = S_IZERO;
      end
      S_IZERO: begin
        ctrl_o.op = OP_ZROW;
        if (stat_i.c_last) state_d = S_IDLE;
      end
      S_IDLE, S_DONE: begin
        state_d = S_IDLE;
        if (accept) begin
          ctrl_o.op = OP_LOAD;
          case (command_i)
            CMD_CLEAR: state_d = S_CLR;
            CMD_PAT:   state_d = S_P_CHK;
            CMD_BUILD: state_d = S_B_CHK;
            CMD_TEXT:  state_d = S_T_CHK;
            CMD_READ:  state_d = S_R_CHK;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        ctrl_o.op = OP_CLR; state_d = S_ZERO;
      end
      S_ZERO: begin
        ctrl_o.op = OP_ZROW;
        if (stat_i.c_last) state_d = S_DONE;
      end
      // Pattern letter
      S_P_CHK: begin
        if (stat_i.built) begin
          state_d = S_DONE;
        end else if (stat_i.dead || !stat_i.letter_ok) begin
          ctrl_o.op = OP_DEAD; state_d = S_P_LAST;
        end else begin
          ctrl_o.op = OP_MULC; state_d = S_P_RD;
        end
      end
      S_P_RD: begin
        ctrl_o.op = OP_RDL; state_d = S_P_INS;
      end
      S_P_INS: begin
        ctrl_o.op = OP_PINS;
        state_d = (stat_i.child_zero && stat_i.room) ? S_P_MULN : S_P_LAST;
      end
      S_P_MULN: begin
        ctrl_o.op = OP_MULC; state_d = S_P_ZROW;
      end
      S_P_ZROW: begin
        ctrl_o.op = OP_ZROW;
        if (stat_i.c_last) state_d = S_P_LAST;
      end
      S_P_LAST: begin
        if (stat_i.last) ctrl_o.op = OP_PLAST;
        state_d = S_DONE;
      end
      // Build links
      S_B_CHK: begin
        ctrl_o.op = OP_BINIT;
        state_d = stat_i.built ? S_DONE : S_B_RDC;
      end
      S_B_RDC: begin
        ctrl_o.op = OP_RDC; state_d = S_B_1;
      end
      S_B_1: begin
        ctrl_o.op = OP_B1;
        state_d = stat_i.c_last ? S_B_Q : S_B_RDC;
      end
      S_B_Q: begin
        if (stat_i.q_more) begin
          ctrl_o.op = OP_RDQ; state_d = S_B_RDF;
        end else begin
          state_d = S_DONE;
        end
      end
      S_B_RDF: begin
        ctrl_o.op = OP_RDF; state_d = S_B_MULF;
      end
      S_B_MULF: begin
        ctrl_o.op = OP_MULF; state_d = S_B_RDV;
      end
      S_B_RDV: begin
        ctrl_o.op = OP_RDV; state_d = S_B_VIA;
      end
      S_B_VIA: begin
        ctrl_o.op = OP_RDVIA; state_d = S_B_2;
      end
      S_B_2: begin
        ctrl_o.op = OP_B2;
        state_d = stat_i.c_last ? S_B_Q : S_B_RDV;
      end
      // Text letter
      S_T_CHK: begin
        if (stat_i.letter_ok) begin
          ctrl_o.op = OP_MULM; state_d = S_T_RD;
        end else begin
          state_d = S_T_S;
        end
      end
      S_T_RD: begin
        ctrl_o.op = OP_RDL; state_d = S_T_S;
      end
      S_T_S: begin
        ctrl_o.op = OP_TS; state_d = S_T_W;
      end
      S_T_W: begin
        if (stat_i.f_nz) begin
          ctrl_o.op = OP_RDW; state_d = S_T_HIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_T_HIT: begin
        ctrl_o.op = OP_HIT; state_d = S_T_W;
      end
      // Read count
      S_R_CHK: begin
        if (stat_i.pidx_ok) begin
          ctrl_o.op = OP_RDP; state_d = S_R_RDH;
        end else begin
          ctrl_o.op = OP_BAD; state_d = S_DONE;
        end
      end
      S_R_RDH: begin
        ctrl_o.op = OP_RDH; state_d = S_R_RES;
      end
      S_R_RES: begin
        ctrl_o.op = OP_RES; state_d = S_DONE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // A result strobe lasts one cycle unless an unknown command follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) (done_o && !accept) |=> !done_o)
    else $error("result strobe held for two cycles");

  // An accepted item always starts work or reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item dropped");

endmodule

// ===== hw/rtl/multi_pattern_match_counter.sv =====
// Top level of the Aho-Corasick multi-pattern match counter.
// One item is taken when start is high and busy low; its single result appears on
// result_o for one cycle with done_o high and cannot be held off. Items run one at
// a time, each stepped by the controller over single-port trie memories with
// registered reads. A pattern letter that allocates a node zeroes the new row one
// entry a cycle; clear zeroes the root row the same way. A text letter visits every
// node on its fail chain; build visits every trie node, and a repeated build does
// not rebuild the links. After reset the block is busy while the root row is zeroed.
module multi_pattern_match_counter #(
  parameter int MAX_NODES    = 4096,
  parameter int MAX_PATTERNS = 256,
  parameter int ALPHABET     = 26,
  parameter int COUNT_BITS   = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mpmc_pkg::item_t   item_i,
  output logic              done_o,
  output mpmc_pkg::result_t result_o
);
  import mpmc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mpmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy),
    .done_o    (done_o)
  );

  mpmc_dpath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .ALPHABET     (ALPHABET),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule
